>>> src/cda_pkg.sv
// Package for the calendar date unit: word types, opcodes, status codes
// and the small calendar helper functions. No dependencies.
package cda_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam logic [21:0] LAST_DAY = 22'd3652058;

    typedef enum logic [2:0] {
        OP_ADD_DAYS = 3'd0, OP_SUB_DAYS = 3'd1, OP_ADD_MONTHS = 3'd2,
        OP_SUB_MONTHS = 3'd3, OP_ADD_YEARS = 3'd4, OP_SUB_YEARS = 3'd5,
        OP_DIFF = 3'd6, OP_NOP = 3'd7
    } op_t;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [4:0]  day_a;
        logic [3:0]  month_a;
        logic [13:0] year_a;
        logic [14:0] amount;
        logic [4:0]  day_b;
        logic [3:0]  month_b;
        logic [13:0] year_b;
    } in_word_t;

    typedef struct packed {
        logic [4:0]  res_day;
        logic [3:0]  res_month;
        logic [13:0] res_year;
        logic [21:0] day_diff;
        logic        a_before_b;
        logic        a_equal_b;
        logic [1:0]  status;
    } out_word_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        logic [2:0]  opcode;
        logic        invalid;
        logic [4:0]  day_a;
        logic [3:0]  month_a;
        logic [13:0] year_a;
        logic [14:0] amount;
        logic [4:0]  day_b;
        logic [3:0]  month_b;
        logic [13:0] year_b;
    } cmd_t;

    // Floor of x / 25 by reciprocal multiplication; exact for every 14-bit x.
    function automatic logic [13:0] div25(input logic [13:0] x);
        logic [27:0] p;
        begin
            p = 28'(x) * 28'd5243;
            return 14'(p >> 17);
        end
    endfunction

    // A year divisible by 100 is one divisible by 4 and by 25; by 400, one
    // divisible by 16 and by 25.
    function automatic logic is_leap(input logic [13:0] y);
        logic [13:0] q;
        logic        by25;
        begin
            q    = div25(y);
            by25 = (y == 14'(q * 14'd25));
            return (y[1:0] == 2'd0) && (!by25 || y[3:0] == 4'd0);
        end
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic [13:0] y);
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
            4'd2: return is_leap(y) ? 5'd29 : 5'd28;
            default: return 5'd0;
        endcase
    endfunction

    function automatic logic valid_date(input logic [4:0] d, input logic [3:0] m,
                                        input logic [13:0] y);
        logic [4:0] lim;
        begin
            lim = month_days(m, y);
            return (y >= 14'd1) && (y <= 14'd9999) && (d >= 5'd1) && (d <= lim);
        end
    endfunction

endpackage

>>> src/calendar_date_arithmetic.sv
// Top level of the Gregorian calendar date unit.
// Instantiates cda_front and cda_back; depends on cda_pkg.
//
// Each command word is checked and queued by the front end, then worked out by
// the back end's sequencer: a day count built month by month, a six-step
// split of a day number back into years, and a month walk. An invalid date or
// a saturated month or year step goes straight to the result. The sequencer
// handles one command at a time and waits while the result word is still
// held; the two-entry queue lets new words in meanwhile.
module calendar_date_arithmetic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cda_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output cda_pkg::out_word_t out_word
);
    import cda_pkg::*;

    cmd_t cmd;
    logic cmd_valid, cmd_ready;

    // Front end with command queue.
    cda_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .ready(in_ready),
        .in_word(in_word), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    // Back end sequencer and result register.
    cda_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
        .cmd(cmd), .valid(out_valid), .ready(out_ready), .out_word(out_word)
    );
endmodule

>>> src/cda_front.sv
// Front end: accepts command words, checks the dates and pushes classified
// commands into a small queue. Depends on cda_pkg.
module cda_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              ready,
    input  cda_pkg::in_word_t in_word,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output cda_pkg::cmd_t     cmd
);
    import cda_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    cmd_t          q_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [PW:0]   cnt_reg;
    cmd_t          c;
    logic          push, pop;

    // Classify the incoming word.
    always_comb
    begin
        c.opcode  = in_word.opcode;
        c.day_a   = in_word.day_a;
        c.month_a = in_word.month_a;
        c.year_a  = in_word.year_a;
        c.amount  = in_word.amount;
        c.day_b   = in_word.day_b;
        c.month_b = in_word.month_b;
        c.year_b  = in_word.year_b;
        c.invalid = !valid_date(in_word.day_a, in_word.month_a, in_word.year_a) ||
                    (in_word.opcode == OP_DIFF &&
                     !valid_date(in_word.day_b, in_word.month_b, in_word.year_b));
    end

    assign ready     = (cnt_reg != (PW+1)'(QUEUE_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_reg];
    assign push      = valid && ready;
    assign pop       = cmd_valid && cmd_ready;

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= c;
        end
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PW'(QUEUE_DEPTH-1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end
endmodule

>>> src/cda_back.sv
// Back end: carries out one command at a time with a stepping sequencer
// (years, then months, then days) and holds the result word. Depends on cda_pkg.
module cda_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cda_pkg::cmd_t      cmd,
    output logic               valid,
    input  logic               ready,
    output cda_pkg::out_word_t out_word
);
    import cda_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_YEARS, S_MONTHS, S_MDIV, S_FINISH, S_DIV, S_SPLIT, S_MSCAN, S_DONE
    } state_t;

    state_t      state_reg;
    cmd_t        cmd_reg;
    logic        second_reg;      // converting date B for a difference
    logic [13:0] yi_reg;          // year whose month lengths the day count adds
    logic [3:0]  mi_reg;
    logic [21:0] acc_reg;         // running day count
    logic [21:0] na_reg;
    logic [21:0] n_reg;           // day number to convert back, or month index
    logic [18:0] q_reg;           // year count built by division
    logic [21:0] r_reg;
    logic [2:0]  dstep_reg;
    logic [13:0] ry_reg;
    logic [3:0]  rm_reg;
    logic [8:0]  rd_reg;
    logic [1:0]  st_reg;
    logic        out_valid_reg;
    out_word_t   out_reg;

    logic [4:0]  cur_d;
    logic [3:0]  cur_m;
    logic [13:0] cur_y;
    logic [13:0] yp;
    logic [13:0] cent;            // yp / 100
    logic [21:0] base_days;
    logic [18:0] mt;              // month index ya*12+ma-1
    logic signed [20:0] mt_s;
    logic [4:0]  lim;
    logic [21:0] sum_add;
    logic signed [23:0] sum_sub;
    logic [26:0] e400_prod;
    logic [4:0]  e400;            // 400-year cycles, low by at most one
    logic [21:0] e4_prod;
    logic [4:0]  e4;              // 4-year cycles, low by at most one
    logic [31:0] mq_prod;
    logic [13:0] mq;              // month index / 12
    logic [3:0]  mr;              // month index % 12
    out_word_t   res_word;
    logic        load_out;

    assign cmd_ready = (state_reg == S_IDLE);
    assign valid     = out_valid_reg;
    assign out_word  = out_reg;

    // Date being turned into a day number.
    assign cur_d = second_reg ? cmd_reg.day_b : cmd_reg.day_a;
    assign cur_m = second_reg ? cmd_reg.month_b : cmd_reg.month_a;
    assign cur_y = second_reg ? cmd_reg.year_b : cmd_reg.year_a;
    assign yp    = cur_y - 14'd1;
    // Whole years before cur_y: 365*p + p/4 - p/100 + p/400.
    assign cent      = div25({2'b0, yp[13:2]});
    assign base_days = 22'(22'(yp) * 22'd365) + 22'(yp[13:2]) - 22'(cent)
                       + 22'(cent[13:2]);
    assign sum_add = acc_reg + 22'(cmd_reg.amount);
    assign sum_sub = $signed({2'b0, acc_reg}) - $signed({9'b0, cmd_reg.amount});
    assign mt      = 19'(19'(cmd_reg.year_a) * 19'd12) + 19'(cmd_reg.month_a) - 19'd1;
    assign lim     = month_days(rm_reg, ry_reg);

    // Quotient estimates by reciprocal multiplication; one compare fixes them.
    assign e400_prod = 27'(n_reg) * 27'd28;
    assign e400      = 5'(e400_prod >> 22);
    assign e4_prod   = r_reg * 22'd44;
    assign e4        = 5'(e4_prod >> 16);

    // Month index split into year and month: t / 12 = (t / 4) / 3, exact here.
    assign mq_prod = 32'(n_reg[21:2]) * 32'd43691;
    assign mq      = 14'(mq_prod >> 17);
    assign mr      = 4'(n_reg - 22'(mq) * 22'd12);

    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || ready);

    always_comb
    begin
        case (cmd_reg.opcode)
            OP_ADD_MONTHS: mt_s = $signed({2'b0, mt}) + $signed({6'b0, cmd_reg.amount});
            OP_SUB_MONTHS: mt_s = $signed({2'b0, mt}) - $signed({6'b0, cmd_reg.amount});
            OP_ADD_YEARS:  mt_s = $signed(21'(mt)) +
                                  $signed(21'(21'(cmd_reg.amount) * 21'd12));
            default:       mt_s = $signed(21'(mt)) -
                                  $signed(21'(21'(cmd_reg.amount) * 21'd12));
        endcase
    end

    // Result word assembled from the finished command.
    always_comb
    begin
        res_word = '0;
        if (st_reg == ST_INVALID)
        begin
            res_word.status = ST_INVALID;
        end
        else if (cmd_reg.opcode == OP_DIFF)
        begin
            res_word.day_diff   = (na_reg > acc_reg) ? na_reg - acc_reg : acc_reg - na_reg;
            res_word.a_before_b = na_reg < acc_reg;
            res_word.a_equal_b  = na_reg == acc_reg;
            res_word.status     = st_reg;
        end
        else
        begin
            res_word.res_day   = 5'(rd_reg);
            res_word.res_month = rm_reg;
            res_word.res_year  = ry_reg;
            res_word.status    = st_reg;
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= load_out || (out_valid_reg && !ready);
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg    <= cmd;
                        second_reg <= 1'b0;
                        st_reg     <= ST_OK;
                        state_reg  <= S_YEARS;
                    end
                end
                // Invalid check, month index clamp, else day count: whole years first.
                S_YEARS:
                begin
                    if (cmd_reg.invalid)
                    begin
                        st_reg    <= ST_INVALID;
                        state_reg <= S_DONE;
                    end
                    else if (cmd_reg.opcode inside {OP_ADD_MONTHS, OP_SUB_MONTHS,
                                                    OP_ADD_YEARS, OP_SUB_YEARS})
                    begin
                        if (mt_s > 21'sd119999)
                        begin
                            st_reg <= ST_RANGE;
                            ry_reg <= 14'd9999; rm_reg <= 4'd12; rd_reg <= 9'd31;
                            state_reg <= S_DONE;
                        end
                        else if (mt_s < 21'sd12)
                        begin
                            st_reg <= ST_RANGE;
                            ry_reg <= 14'd1; rm_reg <= 4'd1; rd_reg <= 9'd1;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            n_reg     <= 22'(mt_s);
                            state_reg <= S_MDIV;
                        end
                    end
                    else
                    begin
                        acc_reg   <= base_days + 22'(cur_d) - 22'd1;
                        mi_reg    <= 4'd1;
                        yi_reg    <= cur_y;
                        state_reg <= S_MONTHS;
                    end
                end
                // Then the months of the current year, one per cycle.
                S_MONTHS:
                begin
                    if (mi_reg < cur_m)
                    begin
                        acc_reg <= acc_reg + 22'(month_days(mi_reg, yi_reg));
                        mi_reg  <= mi_reg + 4'd1;
                    end
                    else if (cmd_reg.opcode == OP_DIFF && !second_reg)
                    begin
                        na_reg     <= acc_reg;
                        second_reg <= 1'b1;
                        state_reg  <= S_YEARS;
                    end
                    else if (cmd_reg.opcode == OP_DIFF)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (cmd_reg.opcode == OP_ADD_DAYS)
                        begin
                            if (sum_add > LAST_DAY)
                            begin
                                n_reg <= LAST_DAY; st_reg <= ST_RANGE;
                            end
                            else
                            begin
                                n_reg <= sum_add;
                            end
                        end
                        else if (cmd_reg.opcode == OP_SUB_DAYS)
                        begin
                            if (sum_sub < 0)
                            begin
                                n_reg <= '0; st_reg <= ST_RANGE;
                            end
                            else
                            begin
                                n_reg <= 22'(sum_sub);
                            end
                        end
                        else
                        begin
                            n_reg <= acc_reg;
                        end
                        dstep_reg <= 3'd0;
                        state_reg <= S_DIV;
                    end
                end
                // Split the month index into year and month, keeping the day.
                S_MDIV:
                begin
                    ry_reg    <= mq;
                    rm_reg    <= mr + 4'd1;
                    rd_reg    <= 9'(cmd_reg.day_a);
                    state_reg <= S_FINISH;
                end
                // Clamp the kept day to the new month's length.
                S_FINISH:
                begin
                    if (rd_reg > 9'(lim))
                    begin
                        rd_reg <= 9'(lim);
                    end
                    state_reg <= S_DONE;
                end
                // Split the day number by 400, 100, 4 and 1 year cycles.
                S_DIV:
                begin
                    case (dstep_reg)
                        3'd0:
                        begin
                            q_reg <= 19'(e400) * 19'd400;
                            r_reg <= n_reg - 22'(e400) * 22'd146097;
                        end
                        3'd1:
                        begin
                            if (r_reg >= 22'd146097)
                            begin
                                q_reg <= q_reg + 19'd400; r_reg <= r_reg - 22'd146097;
                            end
                        end
                        3'd2:
                        begin
                            // The last day of a 400-year cycle stays in the fourth century.
                            if (r_reg >= 22'd109572)
                            begin
                                q_reg <= q_reg + 19'd300; r_reg <= r_reg - 22'd109572;
                            end
                            else if (r_reg >= 22'd73048)
                            begin
                                q_reg <= q_reg + 19'd200; r_reg <= r_reg - 22'd73048;
                            end
                            else if (r_reg >= 22'd36524)
                            begin
                                q_reg <= q_reg + 19'd100; r_reg <= r_reg - 22'd36524;
                            end
                        end
                        3'd3:
                        begin
                            q_reg <= q_reg + 19'(e4) * 19'd4;
                            r_reg <= r_reg - 22'(e4) * 22'd1461;
                        end
                        3'd4:
                        begin
                            if (r_reg >= 22'd1461)
                            begin
                                q_reg <= q_reg + 19'd4; r_reg <= r_reg - 22'd1461;
                            end
                        end
                        default:
                        begin
                            // The last day of a leap year stays in the fourth year.
                            if (r_reg >= 22'd1095)
                            begin
                                q_reg <= q_reg + 19'd3; r_reg <= r_reg - 22'd1095;
                            end
                            else if (r_reg >= 22'd730)
                            begin
                                q_reg <= q_reg + 19'd2; r_reg <= r_reg - 22'd730;
                            end
                            else if (r_reg >= 22'd365)
                            begin
                                q_reg <= q_reg + 19'd1; r_reg <= r_reg - 22'd365;
                            end
                        end
                    endcase
                    dstep_reg <= dstep_reg + 3'd1;
                    if (dstep_reg == 3'd5)
                    begin
                        state_reg <= S_SPLIT;
                    end
                end
                S_SPLIT:
                begin
                    ry_reg    <= 14'(q_reg) + 14'd1;
                    rm_reg    <= 4'd1;
                    state_reg <= S_MSCAN;
                end
                // Walk months while the remainder covers them.
                S_MSCAN:
                begin
                    if (rm_reg < 4'd12 && r_reg >= 22'(lim))
                    begin
                        r_reg  <= r_reg - 22'(lim);
                        rm_reg <= rm_reg + 4'd1;
                    end
                    else
                    begin
                        rd_reg    <= 9'(r_reg) + 9'd1;
                        state_reg <= S_DONE;
                    end
                end
                // Hand the result to the output register when it is free.
                S_DONE:
                begin
                    if (load_out)
                    begin
                        out_reg   <= res_word;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

>>> tb/tb_top.sv
// Testbench for the calendar date unit: drives command words, predicts each
// result with its own calendar arithmetic and checks the results in order.
// Depends on cda_pkg and calendar_date_arithmetic.
module tb_top;
    import cda_pkg::*;

    // In-order store of expected result words and their check.
    class date_scoreboard;
        out_word_t pending[$];
        int mismatches;

        function bit leap_year(int y);
            return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
        endfunction

        function int month_length(int m, int y);
            if (m < 1 || m > 12)
                return 0;
            if (m == 2)
                return leap_year(y) ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11)
                return 30;
            return 31;
        endfunction

        function bit date_ok(int d, int m, int y);
            return y >= 1 && y <= 9999 && m >= 1 && m <= 12 && d >= 1
                && d <= month_length(m, y);
        endfunction

        // Days counted from the first of January of year one.
        function longint day_number(int d, int m, int y);
            longint p;
            longint n;
            p = y - 1;
            n = 365 * p + p / 4 - p / 100 + p / 400;
            for (int i = 1; i < m; i++)
                n += month_length(i, y);
            return n + d - 1;
        endfunction

        // Walk a day number back into a date: whole 400-year cycles, then one year and one month at a time.
        function void split_day_number(longint n, output int d, output int m,
                                       output int y);
            longint r;
            int yy;
            yy = 400 * int'(n / 146097) + 1;
            r = n % 146097;
            while (r >= (leap_year(yy) ? 366 : 365))
            begin
                r -= leap_year(yy) ? 366 : 365;
                yy++;
            end
            m = 1;
            while (r >= month_length(m, yy))
            begin
                r -= month_length(m, yy);
                m++;
            end
            y = yy;
            d = int'(r) + 1;
        endfunction

        function out_word_t predict(in_word_t w);
            out_word_t r;
            longint na;
            longint nb;
            longint t;
            int rd;
            int rm;
            int ry;
            r = '0;
            if (!date_ok(w.day_a, w.month_a, w.year_a) || (op_t'(w.opcode) == OP_DIFF
                && !date_ok(w.day_b, w.month_b, w.year_b)))
            begin
                r.status = ST_INVALID;
            end
            else if (op_t'(w.opcode) == OP_DIFF)
            begin
                na = day_number(w.day_a, w.month_a, w.year_a);
                nb = day_number(w.day_b, w.month_b, w.year_b);
                r.day_diff = 22'(na > nb ? na - nb : nb - na);
                r.a_before_b = na < nb;
                r.a_equal_b = na == nb;
            end
            else if (op_t'(w.opcode) inside {OP_ADD_DAYS, OP_SUB_DAYS, OP_NOP})
            begin
                na = day_number(w.day_a, w.month_a, w.year_a);
                if (op_t'(w.opcode) == OP_ADD_DAYS)
                    na += w.amount;
                else if (op_t'(w.opcode) == OP_SUB_DAYS)
                    na -= w.amount;
                if (na > longint'(LAST_DAY))
                begin
                    na = longint'(LAST_DAY);
                    r.status = ST_RANGE;
                end
                if (na < 0)
                begin
                    na = 0;
                    r.status = ST_RANGE;
                end
                split_day_number(na, rd, rm, ry);
                r.res_day = 5'(rd);
                r.res_month = 4'(rm);
                r.res_year = 14'(ry);
            end
            else
            begin
                if (op_t'(w.opcode) == OP_ADD_MONTHS)
                    t = longint'(w.year_a) * 12 + w.month_a - 1 + w.amount;
                else if (op_t'(w.opcode) == OP_SUB_MONTHS)
                    t = longint'(w.year_a) * 12 + w.month_a - 1 - w.amount;
                else if (op_t'(w.opcode) == OP_ADD_YEARS)
                    t = (longint'(w.year_a) + w.amount) * 12 + w.month_a - 1;
                else
                    t = (longint'(w.year_a) - w.amount) * 12 + w.month_a - 1;
                if (t > 9999 * 12 + 11)
                begin
                    r.status = ST_RANGE;
                    r.res_year = 14'd9999;
                    r.res_month = 4'd12;
                    r.res_day = 5'd31;
                end
                else if (t < 12)
                begin
                    r.status = ST_RANGE;
                    r.res_year = 14'd1;
                    r.res_month = 4'd1;
                    r.res_day = 5'd1;
                end
                else
                begin
                    ry = int'(t / 12);
                    rm = int'(t % 12) + 1;
                    rd = month_length(rm, ry);
                    if (w.day_a < rd)
                        rd = w.day_a;
                    r.res_year = 14'(ry);
                    r.res_month = 4'(rm);
                    r.res_day = 5'(rd);
                end
            end
            return r;
        endfunction

        function void note_command(in_word_t w);
            pending.push_back(predict(w));
        endfunction

        function void check_result(out_word_t got);
            out_word_t exp_w;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", got);
                return;
            end
            exp_w = pending.pop_front();
            if (got.res_day !== exp_w.res_day || got.res_month !== exp_w.res_month
                || got.res_year !== exp_w.res_year || got.day_diff !== exp_w.day_diff
                || got.a_before_b !== exp_w.a_before_b
                || got.a_equal_b !== exp_w.a_equal_b || got.status !== exp_w.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %p, got %p", exp_w, got);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_word_t in_word = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_word_t out_word;

    date_scoreboard board = new();
    int send_idle_pct;
    int recv_idle_pct;
    bit recv_hold;

    calendar_date_arithmetic u_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_word(in_word), .out_valid(out_valid), .out_ready(out_ready),
        .out_word(out_word)
    );

    always #5 clk = ~clk;

    // Record accepted inputs and check outputs at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            board.note_command(in_word);
        if (rst_n && out_valid && out_ready)
            board.check_result(out_word);
    end

    // Receiver readiness, with random stalls and the long hold-off.
    always @(negedge clk)
    begin
        if (recv_hold)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one word, with a random gap before it, and wait for acceptance.
    // Valid stays high afterward until the next gap or the end of stimulus.
    task automatic send_word(in_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_cmd(op_t op, int da, int ma, int ya, int amt,
                            int db, int mb, int yb);
        in_word_t w;
        w.opcode = op;
        w.day_a = 5'(da);
        w.month_a = 4'(ma);
        w.year_a = 14'(ya);
        w.amount = 15'(amt);
        w.day_b = 5'(db);
        w.month_b = 4'(mb);
        w.year_b = 14'(yb);
        send_word(w);
    endtask

    // Random date: mostly valid, sometimes anything the fields hold.
    task automatic rand_date(output int d, output int m, output int y);
        int k;
        k = $urandom_range(99);
        if (k < 8)
        begin
            d = $urandom_range(31);
            m = $urandom_range(15);
            y = $urandom_range(16383);
        end
        else
        begin
            y = k < 20 ? (k < 14 ? $urandom_range(1, 3) : $urandom_range(9997, 9999))
                       : $urandom_range(1, 9999);
            m = $urandom_range(1, 12);
            d = k < 40 ? board.month_length(m, y) - $urandom_range(1) + 1
                       : $urandom_range(1, board.month_length(m, y));
        end
    endtask

    task automatic send_random();
        int da, ma, ya, db, mb, yb, amt, k;
        op_t op;
        rand_date(da, ma, ya);
        rand_date(db, mb, yb);
        op = op_t'($urandom_range(7));
        k = $urandom_range(9);
        amt = k < 2 ? $urandom_range(32767) : (k < 6 ? $urandom_range(40)
                                                     : $urandom_range(4000));
        if (k == 9)
            amt = $urandom_range(1) ? 32767 : 0;
        send_cmd(op, da, ma, ya, amt, db, mb, yb);
    endtask

    // Wait until every expected result word has arrived.
    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        send_idle_pct = 22;
        recv_idle_pct = 83;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // Directed: extremes, every operation, clamping, leap rules, errors.
        send_cmd(OP_ADD_DAYS, 31, 12, 9999, 1, 1, 1, 1);
        send_cmd(OP_SUB_DAYS, 1, 1, 1, 1, 1, 1, 1);
        send_cmd(OP_ADD_DAYS, 28, 2, 2000, 1, 1, 1, 1);
        send_cmd(OP_ADD_DAYS, 28, 2, 1900, 1, 1, 1, 1);
        send_cmd(OP_SUB_DAYS, 1, 3, 2024, 32767, 1, 1, 1);
        send_cmd(OP_ADD_MONTHS, 31, 1, 2023, 1, 1, 1, 1);
        send_cmd(OP_ADD_MONTHS, 31, 3, 2023, 1, 1, 1, 1);
        send_cmd(OP_SUB_MONTHS, 31, 3, 2024, 1, 1, 1, 1);
        send_cmd(OP_ADD_YEARS, 29, 2, 2024, 1, 1, 1, 1);
        send_cmd(OP_SUB_YEARS, 29, 2, 2024, 4, 1, 1, 1);
        send_cmd(OP_ADD_YEARS, 1, 1, 9999, 32767, 1, 1, 1);
        send_cmd(OP_SUB_YEARS, 1, 1, 1, 32767, 1, 1, 1);
        send_cmd(OP_SUB_MONTHS, 15, 1, 1, 1, 1, 1, 1);
        send_cmd(OP_ADD_MONTHS, 15, 12, 9999, 1, 1, 1, 1);
        send_cmd(OP_DIFF, 1, 1, 1, 0, 31, 12, 9999);
        send_cmd(OP_DIFF, 31, 12, 9999, 0, 1, 1, 1);
        send_cmd(OP_DIFF, 5, 6, 2020, 0, 5, 6, 2020);
        send_cmd(OP_DIFF, 5, 6, 2020, 0, 30, 2, 2020);
        send_cmd(OP_NOP, 29, 2, 2000, 123, 1, 1, 1);
        send_cmd(OP_NOP, 29, 2, 2001, 0, 1, 1, 1);
        send_cmd(OP_ADD_DAYS, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(OP_ADD_DAYS, 31, 15, 16383, 32767, 31, 15, 16383);
        send_cmd(OP_ADD_DAYS, 31, 4, 2021, 5, 1, 1, 1);
        send_cmd(OP_DIFF, 1, 1, 2000, 0, 30, 2, 2000);
        // Random phases with the two idling mixes.
        repeat (280) send_random();
        send_idle_pct = 83;
        recv_idle_pct = 22;
        repeat (280) send_random();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Long receiver hold-off while words keep coming, to fill the queue.
        fork
            begin
                recv_hold = 1'b1;
                repeat (400) @(posedge clk);
                recv_hold = 1'b0;
            end
            repeat (30) send_random();
        join
        repeat (260) send_random();
        in_valid <= 1'b0;
        drain();
        if (board.mismatches == 0)
            $display("** calendar_date_arithmetic: PASSED **");
        else
            $display("** calendar_date_arithmetic: FAILED **");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #4000000;
        $display("** calendar_date_arithmetic: FAILED **");
        $finish;
    end
endmodule
